// File: src/sefr_pkg.sv
// ----------------------------------------------------------------------------
// sefr_pkg: shared types and constants of the framed receiver
// Field widths, frame positions, status codes, register indexes and the
// word structs that pass between the receiver's stages.
// ----------------------------------------------------------------------------
package sefr_pkg;

	localparam int BYTE_W    = 8;
	localparam int HALF_W    = 7;
	localparam int PAYLOAD_W = 2 * HALF_W;
	localparam int POS_W     = 3;
	localparam int CFG_IDX_W = 2;

	// byte positions inside a frame (the start byte is position zero)
	localparam logic [POS_W-1:0] POS_CMD  = 3'd1;
	localparam logic [POS_W-1:0] POS_HIGH = 3'd2;
	localparam logic [POS_W-1:0] POS_LOW  = 3'd3;
	localparam logic [POS_W-1:0] POS_SUM  = 3'd4;
	localparam logic [POS_W-1:0] POS_END  = 3'd5;

	localparam logic [HALF_W-1:0] SEVEN_MASK = 7'h7f;
	localparam logic [BYTE_W-1:0] TICK_MAX   = 8'hff;

	// input word kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	// configuration reset values
	localparam logic [BYTE_W-1:0] START_RESET   = 8'h02;
	localparam logic [BYTE_W-1:0] END_RESET     = 8'h03;
	localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'h02;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SUM     = 2'd1,
		STATUS_TIMEOUT = 2'd2,
		STATUS_FRAME   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE    = 1'b0,
		S_COLLECT = 1'b1
	} state_t;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    command;
		logic [PAYLOAD_W-1:0] payload;
		status_t              status;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] timeout_ticks;
	} cfg_t;

endpackage

// File: src/sefr_in_stage.sv
// ----------------------------------------------------------------------------
// sefr_in_stage: input register
// Holds one accepted word until the frame logic consumes it.
// ----------------------------------------------------------------------------
module sefr_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sefr_pkg::item_t in_item,
	input  logic           take,
	output logic           valid_s1,
	output sefr_pkg::item_t item_s1
);
	import sefr_pkg::*;

	// room when empty or when the held word leaves this cycle
	assign in_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: src/sefr_parser.sv
// ----------------------------------------------------------------------------
// sefr_parser: frame state and decision logic
// Tracks the frame being collected, checks the sum and the end byte, counts
// ticks for the timeout and decides whether a word closes a frame.
// ----------------------------------------------------------------------------
module sefr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  sefr_pkg::cfg_t    cfg,
	input  logic             fire,
	input  sefr_pkg::item_t   item,
	output logic             res_valid,
	output sefr_pkg::result_t res
);
	import sefr_pkg::*;

	state_t              state_q, state_d;
	logic [POS_W-1:0]    pos_q;
	logic [BYTE_W-1:0]   cmd_q;
	logic [HALF_W-1:0]   high_q;
	logic [HALF_W-1:0]   low_q;
	logic [BYTE_W-1:0]   sum_q;
	logic                matched_q;
	logic [BYTE_W-1:0]   ticks_q;

	logic                is_tick;
	logic                is_start;
	logic                is_end;
	logic                last_pos;
	logic [BYTE_W-1:0]   ticks_inc;
	logic                emit;
	status_t             emit_status;

	assign is_tick   = (item.op == OP_TICK);
	assign is_start  = !is_tick && (item.rx_byte == cfg.start_byte);
	assign is_end    = (item.rx_byte == cfg.end_byte);
	assign last_pos  = (pos_q >= POS_END);
	assign ticks_inc = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 8'd1;

	// frame close decision
	always_comb begin
		emit        = 1'b0;
		emit_status = STATUS_OK;
		if (state_q == S_COLLECT) begin
			if (is_tick) begin
				emit        = (ticks_inc >= cfg.timeout_ticks);
				emit_status = STATUS_TIMEOUT;
			end else if (last_pos) begin
				emit = 1'b1;
				if (!is_end) begin
					emit_status = STATUS_FRAME;
				end else if (!matched_q) begin
					emit_status = STATUS_SUM;
				end else begin
					emit_status = STATUS_OK;
				end
			end else if (is_end) begin
				emit        = 1'b1;
				emit_status = STATUS_FRAME;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (is_start) begin
					state_d = S_COLLECT;
				end
			end
			S_COLLECT: begin
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result word, command and payload zeros unless the frame is good
	always_comb begin
		res_valid   = fire && emit;
		res.status  = emit_status;
		res.command = '0;
		res.payload = '0;
		if (emit_status == STATUS_OK) begin
			res.command = cmd_q;
			res.payload = {high_q, low_q};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			sum_q     <= '0;
			matched_q <= 1'b0;
			ticks_q   <= '0;
		end else if (fire) begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				if (is_start) begin
					pos_q     <= POS_CMD;
					sum_q     <= item.rx_byte;
					matched_q <= 1'b0;
					ticks_q   <= '0;
				end
			end else if (emit) begin
				pos_q     <= '0;
				sum_q     <= '0;
				matched_q <= 1'b0;
				ticks_q   <= '0;
			end else if (is_tick) begin
				ticks_q <= ticks_inc;
			end else begin
				if (pos_q == POS_SUM) begin
					matched_q <= (item.rx_byte == sum_q);
				end
				if (pos_q < POS_SUM) begin
					sum_q <= sum_q + item.rx_byte;
				end
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	// held frame fields
	always_ff @(posedge clk) begin
		if (fire && state_q == S_COLLECT && !is_tick && !emit) begin
			case (pos_q)
				POS_CMD:  cmd_q  <= item.rx_byte;
				POS_HIGH: high_q <= item.rx_byte[HALF_W-1:0] & SEVEN_MASK;
				POS_LOW:  low_q  <= item.rx_byte[HALF_W-1:0] & SEVEN_MASK;
				default: ;
			endcase
		end
	end

endmodule

// File: src/sefr_out_reg.sv
// ----------------------------------------------------------------------------
// sefr_out_reg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module sefr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sefr_pkg::result_t res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output sefr_pkg::result_t out_res
);
	import sefr_pkg::*;

	result_t res_q;
	logic    valid_q;

	// room when empty or when the held word is taken this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

endmodule

// File: src/stx_etx_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_unit: start/end byte frame receiver
// Collects six-byte frames with an additive checksum from a byte and tick
// stream and reports command, payload and status.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the result register has room: a
// received byte or a timer tick, told apart by s_tuser. Each word goes
// through an input register, one pass of frame logic and a result register;
// its result is loaded as the word leaves the input register, and words may follow back to back without gaps. While
// a result waits on m_tready the next word is held in the input register, and
// the input side stalls once that register is full. Bytes are dropped until
// the start byte arrives; the frame then closes on its sixth byte, on an
// early end byte, or when the tick count reaches timeout_ticks. Error results
// carry zero command and payload. The user must write registers through the
// cfg port only while the unit is idle (not enforced); there is no clearing pass.
module stx_etx_frame_receiver_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // rx_byte
	input  logic [0:0]                      s_tuser,   // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // command, payload, zero pad
	output logic [1:0]                      m_tuser,   // status
	input  logic                            cfg_we,
	input  logic [sefr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sefr_pkg::BYTE_W-1:0]     cfg_wdata
);
	import sefr_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    fire;
	logic    out_free;
	logic    res_valid;
	result_t res;
	result_t out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= START_RESET;
			cfg_q.end_byte      <= END_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START:   cfg_q.start_byte    <= cfg_wdata;
				CFG_END:     cfg_q.end_byte      <= cfg_wdata;
				CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input word unpacking
	assign in_item.op      = s_tuser[0];
	assign in_item.rx_byte = s_tdata;

	// a held word is processed when the result register has room
	assign fire = valid_s1 && out_free;

	sefr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sefr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sefr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// result word packing
	assign m_tdata = {2'b00, out_res.payload, out_res.command};
	assign m_tuser = out_res.status;

endmodule

// File: src/sefr_checker.sv
// ----------------------------------------------------------------------------
// sefr_checker: port-level checks of the frame receiver
// Watches the result channel for stall behavior and zeroed error words.
// ----------------------------------------------------------------------------
module sefr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import sefr_pkg::*;

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// a stalled word keeps its contents
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// error words carry zero command and payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == 24'd0))
		else $error("error result with nonzero command or payload");

	// pad bits above the payload stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:22] == 2'b00))
		else $error("result pad bits set");

endmodule

bind stx_etx_frame_receiver_unit sefr_checker u_sefr_checker (.*);
